// ----- design/jlr_pkg.sv -----
// ---------------------------------------------------------------------------
// jlr_pkg: shared types and helpers for the jerk limited ramp
// Holds field widths, register index codes, item kind codes, the
// configuration and state structs and the saturating arithmetic helpers.
// ---------------------------------------------------------------------------
package jlr_pkg;

   localparam int DataWidth = 32;
   localparam int LimitWidth = 31;
   localparam int SnapWidth = 16;
   localparam int CsrIndexWidth = 2;
   localparam int CsrDataWidth = 31;

   // Register index codes on the configuration port.
   localparam logic [CsrIndexWidth-1:0] CSR_ACCEL_LIMIT = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_JERK_LIMIT = 2'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_SNAP_WINDOW = 2'd2;

   // Register reset values.
   localparam logic [LimitWidth-1:0] AccelLimitReset = 31'd65536;
   localparam logic [LimitWidth-1:0] JerkLimitReset = 31'd6554;
   localparam logic [SnapWidth-1:0] SnapWindowReset = 16'd1311;

   // Item kinds.
   localparam logic KIND_RAMP = 1'b0;
   localparam logic KIND_LOAD = 1'b1;

   typedef struct packed {
      logic [LimitWidth-1:0] accel_limit;
      logic [LimitWidth-1:0] jerk_limit;
      logic [SnapWidth-1:0] snap_window;
   } jlr_cfg_type;

   typedef struct packed {
      logic signed [DataWidth-1:0] velocity;
      logic signed [DataWidth-1:0] accel;
   } jlr_state_type;

   // Saturate a 33-bit signed sum into the 32-bit signed range.
   function automatic logic signed [DataWidth-1:0] sat32(input logic signed [DataWidth:0] x);
      logic signed [DataWidth-1:0] result;
      if (x[DataWidth] != x[DataWidth-1]) begin
         result = x[DataWidth] ? {1'b1, {(DataWidth-1){1'b0}}} : {1'b0, {(DataWidth-1){1'b1}}};
      end else begin
         result = x[DataWidth-1:0];
      end
      return result;
   endfunction

   // Clamp a 33-bit signed value to plus or minus an unsigned 31-bit limit.
   function automatic logic signed [DataWidth-1:0] clamp_sym(
      input logic signed [DataWidth:0] x,
      input logic [LimitWidth-1:0] lim
   );
      logic signed [DataWidth:0] hi;
      logic signed [DataWidth:0] lo;
      logic signed [DataWidth:0] sel;
      hi = $signed({2'b00, lim});
      lo = -hi;
      if (x > hi) begin
         sel = hi;
      end else if (x < lo) begin
         sel = lo;
      end else begin
         sel = x;
      end
      return sel[DataWidth-1:0];
   endfunction

endpackage

// ----- design/jlr_req_if.sv -----
// ---------------------------------------------------------------------------
// jlr_req_if: request channel of the jerk limited ramp
// Carries one item per beat: the item kind and the target or load velocity.
// ---------------------------------------------------------------------------
interface jlr_req_if;
   logic valid;
   logic ready;
   logic kind;
   logic signed [31:0] value;

   modport source (output valid, output kind, output value, input ready);
   modport sink (input valid, input kind, input value, output ready);
endinterface

// ----- design/jlr_rsp_if.sv -----
// ---------------------------------------------------------------------------
// jlr_rsp_if: response channel of the jerk limited ramp
// Carries one result per beat: commanded velocity and acceleration.
// ---------------------------------------------------------------------------
interface jlr_rsp_if;
   logic valid;
   logic ready;
   logic signed [31:0] velocity;
   logic signed [31:0] accel;

   modport source (output valid, output velocity, output accel, input ready);
   modport sink (input valid, input velocity, input accel, output ready);
endinterface

// ----- design/jlr_step.sv -----
// ---------------------------------------------------------------------------
// jlr_step: one profile update
// Computes the next velocity and acceleration from the current state, one
// item and the limits: clamp, jerk limit, saturating add and snap window.
// ---------------------------------------------------------------------------
module jlr_step
   import jlr_pkg::*;
(
   input  logic                        kind,
   input  logic signed [DataWidth-1:0] value,
   input  jlr_state_type               cur,
   input  jlr_cfg_type                 cfg,
   output jlr_state_type               nxt
);

   logic signed [DataWidth:0]   vel_err;
   logic signed [DataWidth-1:0] want;
   logic signed [DataWidth:0]   accel_err;
   logic signed [DataWidth-1:0] delta;
   logic signed [DataWidth-1:0] new_accel;
   logic signed [DataWidth-1:0] new_velocity;
   logic signed [DataWidth:0]   rem_err;
   logic signed [DataWidth:0]   snap_hi;
   logic                        snapped;

   // Desired acceleration is the velocity error clamped to the accel limit.
   assign vel_err = {value[DataWidth-1], value} - {cur.velocity[DataWidth-1], cur.velocity};
   assign want = clamp_sym(vel_err, cfg.accel_limit);

   // Acceleration moves toward the desired value by at most the jerk limit.
   assign accel_err = {want[DataWidth-1], want} - {cur.accel[DataWidth-1], cur.accel};
   assign delta = clamp_sym(accel_err, cfg.jerk_limit);
   assign new_accel = sat32({cur.accel[DataWidth-1], cur.accel} + {delta[DataWidth-1], delta});

   // Velocity integrates the new acceleration with saturation.
   assign new_velocity = sat32({cur.velocity[DataWidth-1], cur.velocity}
                               + {new_accel[DataWidth-1], new_accel});

   // Lock onto the target when the remaining error is strictly inside the window.
   assign rem_err = {value[DataWidth-1], value} - {new_velocity[DataWidth-1], new_velocity};
   assign snap_hi = $signed({{(DataWidth+1-SnapWidth){1'b0}}, cfg.snap_window});
   assign snapped = (rem_err < snap_hi) && (rem_err > -snap_hi);

   always_comb begin
      if (kind == KIND_LOAD || snapped) begin
         nxt.velocity = value;
         nxt.accel = '0;
      end else begin
         nxt.velocity = new_velocity;
         nxt.accel = new_accel;
      end
   end

endmodule

// ----- design/jerk_limited_ramp_core.sv -----
// ---------------------------------------------------------------------------
// jerk_limited_ramp_core: S-curve velocity profile generator
// Q16.16 velocity ramp with acceleration and jerk limits and a snap window.
// ---------------------------------------------------------------------------
// Each request beat carries kind and value. A ramp item (kind 0) steps the
// velocity toward value under the acceleration and jerk limits; a load item
// (kind 1) sets the velocity to value and clears the acceleration. Every
// request gives exactly one response beat with the velocity and acceleration
// after that item. The limits are to be written through the csr port only while
// no item is in flight; the block itself does not enforce this.
// A request is registered in the request register at acceptance, and the step
// result is registered in the state and response registers when the response
// register is free. One item is taken every cycle while responses are taken.
// Reset clears velocity and acceleration, restores the default limits and
// empties both registers; req ready is low during reset.
// While the response is not taken it holds; one more request waits in the
// request register and req ready drops until the response leaves.
// ---------------------------------------------------------------------------
module jerk_limited_ramp_core
   import jlr_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   jlr_req_if.sink                  req_bus,
   jlr_rsp_if.source                rsp_bus,
   input  logic                     csr_write_enable,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_write_data
);

   jlr_cfg_type                 cfg_ff;
   logic                        req_valid_ff;
   logic                        req_kind_ff;
   logic signed [DataWidth-1:0] req_value_ff;
   jlr_state_type               state_ff;
   logic                        rsp_valid_ff;
   jlr_state_type               state_in;
   logic                        out_free;
   logic                        advance;
   logic                        req_take;

   // Handshake: the response register frees when empty or taken.
   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign advance = req_valid_ff && out_free;
   assign req_bus.ready = !reset && (!req_valid_ff || out_free);
   assign req_take = req_bus.valid && req_bus.ready;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.accel_limit <= AccelLimitReset;
         cfg_ff.jerk_limit <= JerkLimitReset;
         cfg_ff.snap_window <= SnapWindowReset;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_ACCEL_LIMIT: cfg_ff.accel_limit <= csr_write_data[LimitWidth-1:0];
            CSR_JERK_LIMIT: cfg_ff.jerk_limit <= csr_write_data[LimitWidth-1:0];
            CSR_SNAP_WINDOW: cfg_ff.snap_window <= csr_write_data[SnapWidth-1:0];
            default: ;
         endcase
      end
   end

   // Request register.
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         req_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         req_kind_ff <= req_bus.kind;
         req_value_ff <= req_bus.value;
      end
   end

   // Profile update from the registered request.
   jlr_step u_step (
      .kind  (req_kind_ff),
      .value (req_value_ff),
      .cur   (state_ff),
      .cfg   (cfg_ff),
      .nxt   (state_in)
   );

   // Profile state and response register advance together.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            state_ff <= state_in;
         end
         if (out_free) begin
            rsp_valid_ff <= req_valid_ff;
         end
      end
   end

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.velocity = state_ff.velocity;
   assign rsp_bus.accel = state_ff.accel;

endmodule

// ----- design/jlr_checker.sv -----
// ---------------------------------------------------------------------------
// jlr_checker: port level checks for the jerk limited ramp
// Watches the channel ports over time and is bound to the top level.
// ---------------------------------------------------------------------------
module jlr_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_kind,
   input logic [31:0] req_value,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_velocity,
   input logic [31:0] rsp_accel
);

   // The response channel is empty right after reset.
   a_empty_after_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // A stalled response beat holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_velocity) && $stable(rsp_accel))
      else $error("stalled response changed");

   // A new response beat always stems from an earlier accepted request.
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("response without request");

   // A load item flowing freely returns the loaded velocity and zero accel.
   a_load_result: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_kind && rsp_ready) ##1 rsp_ready
      |=> rsp_valid && rsp_velocity == $past(req_value, 2) && rsp_accel == 32'd0)
      else $error("load item result mismatch");

endmodule

bind jerk_limited_ramp_core jlr_checker u_jlr_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_bus.valid),
   .req_ready    (req_bus.ready),
   .req_kind     (req_bus.kind),
   .req_value    (req_bus.value),
   .rsp_valid    (rsp_bus.valid),
   .rsp_ready    (rsp_bus.ready),
   .rsp_velocity (rsp_bus.velocity),
   .rsp_accel    (rsp_bus.accel)
);
